@@ hw/rtl/wes_pkg.sv @@
// Package for the weighted event selector.
// Holds default sizes, item and status codes, controller states and the
// command/status structs shared by the controller and the datapath.
`default_nettype none

package wes_pkg;

  localparam int unsigned MaxEventsDef  = 1024;
  localparam int unsigned WeightBitsDef = 32;

  localparam int unsigned IndexW   = 10;
  localparam int unsigned InWeightW = 32;
  localparam int unsigned UniformW = 32;
  localparam int unsigned TotalOutW = 42;
  localparam int unsigned CountW   = 11;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic RegActiveCount = 1'b0;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_SELECT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_WRITTEN = 2'd0,
    ST_CHOSEN  = 2'd1,
    ST_NONE    = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_RD,
    S_WR_UPD,
    S_MUL_LO,
    S_MUL_HI,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic    accept;
    logic    clr_en;
    logic    wr_rd;
    logic    wr_upd;
    logic    mul_lo;
    logic    mul_hi;
    logic    scan_rd;
    logic    res_load;
    status_e res_code;
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic is_select;
    logic out_of_range;
    logic total_zero;
    logic clr_last;
    logic scan_done;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/wes_ctrl.sv @@
// Controller for the weighted event selector.
// Sequences clear, write, scale and scan steps; depends on wes_pkg.
`default_nettype none

module wes_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  wes_pkg::dp_status_t  status_i,
  output wes_pkg::cmd_t        cmd_o
);

  wes_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wes_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      wes_pkg::S_CLEAR: begin
        if (status_i.clr_last) state_d = wes_pkg::S_IDLE;
      end
      wes_pkg::S_IDLE: begin
        if (start) begin
          if (!status_i.is_select) begin
            if (!status_i.out_of_range) state_d = wes_pkg::S_WR_RD;
          end else if (!status_i.total_zero) begin
            state_d = wes_pkg::S_MUL_LO;
          end
        end
      end
      wes_pkg::S_WR_RD:  state_d = wes_pkg::S_WR_UPD;
      wes_pkg::S_WR_UPD: state_d = wes_pkg::S_IDLE;
      wes_pkg::S_MUL_LO: state_d = wes_pkg::S_MUL_HI;
      wes_pkg::S_MUL_HI: state_d = wes_pkg::S_SCAN;
      wes_pkg::S_SCAN: begin
        if (status_i.scan_done) state_d = wes_pkg::S_IDLE;
      end
      default: state_d = wes_pkg::S_CLEAR;
    endcase
    if (status_i.cfg_wr) state_d = wes_pkg::S_CLEAR;
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res_code = wes_pkg::ST_WRITTEN;
    case (state_q)
      wes_pkg::S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      wes_pkg::S_IDLE: begin
        cmd_o.accept = start;
        if (start) begin
          if (!status_i.is_select) begin
            if (status_i.out_of_range) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_code = wes_pkg::ST_RANGE;
            end
          end else if (status_i.total_zero) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_code = wes_pkg::ST_NONE;
          end
        end
      end
      wes_pkg::S_WR_RD: begin
        cmd_o.wr_rd = 1'b1;
      end
      wes_pkg::S_WR_UPD: begin
        cmd_o.wr_upd   = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_code = wes_pkg::ST_WRITTEN;
      end
      wes_pkg::S_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
      end
      wes_pkg::S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
      end
      wes_pkg::S_SCAN: begin
        if (status_i.scan_done) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = wes_pkg::ST_CHOSEN;
        end else begin
          cmd_o.scan_rd = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign busy = (state_q != wes_pkg::S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/wes_datapath.sv @@
// Datapath for the weighted event selector: weight memory, running total,
// threshold multiplier, prefix scan, register port and result registers.
// Depends on wes_pkg; driven by wes_ctrl.
`default_nettype none

module wes_datapath #(
  parameter int unsigned MAX_EVENTS  = wes_pkg::MaxEventsDef,
  parameter int unsigned WEIGHT_BITS = wes_pkg::WeightBitsDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [wes_pkg::ApbAddrW-1:0]       paddr,
  input  wire  [wes_pkg::ApbDataW-1:0]       pwdata,
  output logic [wes_pkg::ApbDataW-1:0]       prdata,
  output logic                               pready,
  input  wire                                kind_i,
  input  wire  [wes_pkg::IndexW-1:0]         index_i,
  input  wire  [wes_pkg::InWeightW-1:0]      weight_i,
  input  wire  [wes_pkg::UniformW-1:0]       uniform_i,
  input  wes_pkg::cmd_t                      cmd_i,
  output wes_pkg::dp_status_t                status_o,
  output logic                               done_o,
  output logic [1:0]                         status_code_o,
  output logic [wes_pkg::IndexW-1:0]         event_index_o,
  output logic [wes_pkg::TotalOutW-1:0]      total_weight_o
);

  localparam int unsigned AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int unsigned TW = WEIGHT_BITS + AW;
  localparam int unsigned CW = ($clog2(MAX_EVENTS + 1) > wes_pkg::CountW) ?
                               $clog2(MAX_EVENTS + 1) : wes_pkg::CountW;

  logic [WEIGHT_BITS-1:0] mem [MAX_EVENTS];

  logic [wes_pkg::CountW-1:0] count_q;
  logic [TW-1:0]              total_q;
  logic [AW-1:0]              addr_q;
  logic [wes_pkg::IndexW-1:0] idx_q;
  logic [WEIGHT_BITS-1:0]     w_q;
  logic [wes_pkg::UniformW-1:0] u_q;
  logic [WEIGHT_BITS-1:0]     rdata_q;
  logic [AW-1:0]              ridx_q;
  logic                       rvld_q;
  logic [63:0]                prod_q;
  logic [TW-1:0]              thresh_q;
  logic [TW-1:0]              prefix_q;
  logic                       done_q;
  wes_pkg::status_e           code_q;
  logic [wes_pkg::IndexW-1:0] evidx_q;

  logic                   cfg_wr;
  logic [CW-1:0]          count_ext;
  logic [CW-1:0]          live_n;
  logic [63:0]            total_ext;
  logic [31:0]            mul_a;
  logic [63:0]            mul_p;
  logic [TW-1:0]          prefix_d;
  logic [TW-1:0]          total_d;
  logic                   hit;
  logic                   last;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [WEIGHT_BITS-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;

  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == wes_pkg::RegActiveCount);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == wes_pkg::RegActiveCount) ?
                  wes_pkg::ApbDataW'(count_q) : '0;

  assign count_ext = CW'(count_q);
  assign live_n    = (count_ext > CW'(MAX_EVENTS)) ? CW'(MAX_EVENTS) : count_ext;

  assign total_ext = 64'(total_q);
  assign mul_a     = cmd_i.mul_hi ? total_ext[63:32] : total_ext[31:0];
  assign mul_p     = 64'(mul_a) * 64'(u_q);

  assign prefix_d = prefix_q + TW'(rdata_q);
  assign hit      = prefix_d > thresh_q;
  assign last     = (CW'(ridx_q) == (live_n - CW'(1)));
  assign total_d  = total_q - TW'(rdata_q) + TW'(w_q);

  assign mem_we    = cmd_i.clr_en || cmd_i.wr_upd;
  assign mem_waddr = cmd_i.clr_en ? addr_q : AW'(idx_q);
  assign mem_wdata = cmd_i.clr_en ? '0 : w_q;
  assign mem_raddr = cmd_i.wr_rd ? AW'(idx_q) : addr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
    ridx_q  <= mem_raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      addr_q  <= '0;
      rvld_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      rvld_q <= cmd_i.scan_rd;
      done_q <= cmd_i.res_load;
      if (cfg_wr) begin
        count_q <= pwdata[wes_pkg::CountW-1:0];
        total_q <= '0;
        addr_q  <= '0;
      end else begin
        if (cmd_i.wr_upd) total_q <= total_d;
        if (cmd_i.mul_hi) begin
          addr_q <= '0;
        end else if (cmd_i.clr_en || cmd_i.scan_rd) begin
          addr_q <= addr_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q <= index_i;
      w_q   <= WEIGHT_BITS'(weight_i);
      u_q   <= uniform_i;
    end
    if (cmd_i.mul_lo) begin
      prod_q <= mul_p;
    end
    if (cmd_i.mul_hi) begin
      thresh_q <= TW'(mul_p + (prod_q >> 32));
      prefix_q <= '0;
    end else if (rvld_q) begin
      prefix_q <= prefix_d;
    end
    if (cmd_i.res_load) begin
      code_q  <= cmd_i.res_code;
      evidx_q <= (cmd_i.res_code == wes_pkg::ST_CHOSEN) ?
                 wes_pkg::IndexW'(ridx_q) : '0;
    end
  end

  always_comb begin
    status_o              = '0;
    status_o.cfg_wr       = cfg_wr;
    status_o.is_select    = (kind_i == wes_pkg::KIND_SELECT);
    status_o.out_of_range = (CW'(index_i) >= live_n);
    status_o.total_zero   = (total_q == '0) || (live_n == '0);
    status_o.clr_last     = (addr_q == AW'(MAX_EVENTS - 1));
    status_o.scan_done    = rvld_q && (hit || last);
  end

  assign done_o         = done_q;
  assign status_code_o  = code_q;
  assign event_index_o  = evidx_q;
  assign total_weight_o = wes_pkg::TotalOutW'(total_q);

endmodule

`default_nettype wire

@@ hw/rtl/weighted_event_selector.sv @@
// Top level of the weighted event selector.
// Joins wes_ctrl and wes_datapath; depends on wes_pkg.
//
// Items are taken with start while busy is low. A weight write reads the old
// weight, then writes the entry, updates the running total and returns its
// result on done; a select that picks entry k returns it after a two-step
// threshold multiply and a one-entry-per-cycle scan of the weight memory up
// to entry k. An out-of-range write or a select with zero total answers on
// the next cycle. Results show for one cycle with done high and cannot be
// held off. Reset and each active_count write start a pass that clears all
// MAX_EVENTS weight entries with busy high; register writes are taken throughout.
`default_nettype none

module weighted_event_selector #(
  parameter int unsigned MAX_EVENTS  = wes_pkg::MaxEventsDef,
  parameter int unsigned WEIGHT_BITS = wes_pkg::WeightBitsDef
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [wes_pkg::ApbAddrW-1:0]     paddr,
  input  wire  [wes_pkg::ApbDataW-1:0]     pwdata,
  output logic [wes_pkg::ApbDataW-1:0]     prdata,
  output logic                             pready,
  input  wire                              start,
  output logic                             busy,
  input  wire                              kind_i,
  input  wire  [wes_pkg::IndexW-1:0]       index_i,
  input  wire  [wes_pkg::InWeightW-1:0]    weight_i,
  input  wire  [wes_pkg::UniformW-1:0]     uniform_i,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic [wes_pkg::IndexW-1:0]       event_index_o,
  output logic [wes_pkg::TotalOutW-1:0]    total_weight_o
);

  wes_pkg::cmd_t       cmd;
  wes_pkg::dp_status_t dp_status;

  wes_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (dp_status),
    .cmd_o    (cmd)
  );

  wes_datapath #(
    .MAX_EVENTS  (MAX_EVENTS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .kind_i         (kind_i),
    .index_i        (index_i),
    .weight_i       (weight_i),
    .uniform_i      (uniform_i),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .done_o         (done_o),
    .status_code_o  (status_o),
    .event_index_o  (event_index_o),
    .total_weight_o (total_weight_o)
  );

endmodule

`default_nettype wire
